// ----- src/signed_division_magic_number_unit_macros.svh -----
// Assertion macros shared by the magic number unit RTL.
`ifndef SIGNED_DIVISION_MAGIC_NUMBER_UNIT_MACROS_SVH
`define SIGNED_DIVISION_MAGIC_NUMBER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDMN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdmn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SDMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdmn assertion failed");

`endif

// ----- src/sdmn_pkg.sv -----
// Shared constants and operand types of the magic number unit.
`default_nettype none

package sdmn_pkg;

    localparam int WORD_W   = 32;             // divisor and remainder width
    localparam int QUOT_W   = 34;             // quotient register width
    localparam int MULT_W   = 34;             // magic multiplier width
    localparam int SHIFT_W  = 5;              // post shift width
    localparam int STEP_W   = 6;              // step counter, holds 0..32
    localparam int IDX_W    = 5;              // dividend bit index
    localparam int OUT_W    = 40;             // result tdata, padded to bytes

    localparam logic [STEP_W-1:0] MAX_STEPS = 6'd32;
    localparam logic [IDX_W-1:0]  MSB_IDX   = 5'd31;
    localparam logic [WORD_W-1:0] MIN_DIV   = 32'h8000_0000;
    localparam logic [WORD_W-1:0] TWO31     = 32'h8000_0000;

    // Operands of one restoring shift/subtract step
    typedef struct packed {
        logic [QUOT_W-1:0] q;
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] d;
        logic              din;
    } sdmn_step_in_t;

    // Result of one step
    typedef struct packed {
        logic [QUOT_W-1:0] q;
        logic [WORD_W-1:0] r;
    } sdmn_step_out_t;

endpackage

`default_nettype wire

// ----- src/sdmn_div_step.sv -----
// Shared restoring divide step: shift in one dividend bit, compare, subtract.
`default_nettype none

module sdmn_div_step (
    input  wire sdmn_pkg::sdmn_step_in_t  op_i,
    output      sdmn_pkg::sdmn_step_out_t res_o
);
    import sdmn_pkg::*;

    logic [WORD_W:0] rem_shift;
    logic [WORD_W:0] rem_diff;
    logic            ge;

    // Partial remainder stays below the divisor, so WORD_W+1 bits suffice
    assign rem_shift = {op_i.r, op_i.din};
    assign rem_diff  = rem_shift - {1'b0, op_i.d};
    assign ge        = (rem_shift >= {1'b0, op_i.d});

    assign res_o.r = ge ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
    assign res_o.q = {op_i.q[QUOT_W-2:0], ge};

endmodule

`default_nettype wire

// ----- src/signed_division_magic_number_unit.sv -----
// Magic multiplier and post shift generator for signed 32-bit constant division.
//
// Usage:
//   Input channel s_*: one signed 32-bit divisor per transfer in s_tdata.
//   Result channel m_*: m_tdata[33:0] magic multiplier (signed), m_tdata[38:34]
//   post shift; m_tuser is the invalid flag (zero or most negative divisor).
//   The block handles one divisor at a time; s_tready is high only while idle.
//   Operation: a single restoring divide-step unit is shared by three 32-step
//   divisions (t / |d|, 2^31 / anc, 2^31 / |d|) followed by the refinement
//   loop, each step of which takes two unit steps and one delta compare.
//   The refinement loop runs 1 to 32 steps. Invalid divisors skip the divisions
//   and go straight to the final state; the next divisor is taken once the unit
//   is back in idle.
//   A finished result sits in an output register; a new divisor may be
//   accepted while it waits. If the receiver still stalls when the next
//   result is ready, the unit holds in its final state until the slot frees.
//   Reset (aresetn low, synchronous) returns to idle and drops m_tvalid.
`default_nettype none

module signed_division_magic_number_unit (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output      logic                      s_tready,
    input  wire logic [sdmn_pkg::WORD_W-1:0] s_tdata,   // [31:0] divisor
    output      logic                      m_tvalid,
    input  wire logic                      m_tready,
    output      logic [sdmn_pkg::OUT_W-1:0] m_tdata,    // [33:0] magic_multiplier,
                                                        // [38:34] post_shift, [39] 0
    output      logic                      m_tuser      // [0] invalid
);
    import sdmn_pkg::*;

    `include "signed_division_magic_number_unit_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_T,
        ST_CALC_ANC,
        ST_DIV_ANC,
        ST_DIV_AD,
        ST_STEP2,
        ST_STEP1,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [WORD_W-1:0]   ad_reg;
    logic [WORD_W-1:0]   t_reg;
    logic [WORD_W-1:0]   anc_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic                invalid_reg;
    logic [QUOT_W-1:0]   q1_reg, q2_reg;
    logic [WORD_W-1:0]   r1_reg, r2_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic                m_tuser_reg;

    sdmn_step_in_t       unit_in;
    sdmn_step_out_t      unit_out;
    logic                sel_q1;
    logic [WORD_W-1:0]   anc_next;
    logic [WORD_W-1:0]   delta;
    logic                keep_going;
    logic [MULT_W-1:0]   mag_pos;
    logic [MULT_W-1:0]   mag_final;
    logic [SHIFT_W-1:0]  shift_final;
    logic                out_free;
    logic                in_check;
    logic                rem_ok;

    // Operand selection for the shared divide step
    assign sel_q1 = (state_reg == ST_DIV_ANC) || (state_reg == ST_STEP1);

    always_comb begin
        unit_in.q = sel_q1 ? q1_reg : q2_reg;
        unit_in.r = sel_q1 ? r1_reg : r2_reg;
        unit_in.d = sel_q1 ? anc_reg : ad_reg;
        unit_in.din = 1'b0;
        unique case (state_reg)
            ST_DIV_T:               unit_in.din = t_reg[idx_reg];
            ST_DIV_ANC, ST_DIV_AD:  unit_in.din = (idx_reg == MSB_IDX);
            default:                unit_in.din = 1'b0;
        endcase
    end

    sdmn_div_step u_step (
        .op_i  (unit_in),
        .res_o (unit_out)
    );

    // anc = t - 1 - (t mod |d|); remainder of the first division is in r2
    assign anc_next = t_reg - {{(WORD_W-1){1'b0}}, 1'b1} - r2_reg;

    // Loop exit test
    assign delta      = ad_reg - r2_reg;
    assign keep_going = (q1_reg < {{(QUOT_W-WORD_W){1'b0}}, delta}) ||
                        ((q1_reg == {{(QUOT_W-WORD_W){1'b0}}, delta}) &&
                         (r1_reg == '0));

    // Final multiplier and shift
    assign mag_pos     = q2_reg + {{(MULT_W-1){1'b0}}, 1'b1};
    assign mag_final   = zero_reg ? '0 : (neg_reg ? (~mag_pos + MULT_W'(1)) : mag_pos);
    assign shift_final = zero_reg ? '0 : SHIFT_W'(step_reg - STEP_W'(1));

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // FINISH reloads the output slot itself
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        neg_reg  <= s_tdata[WORD_W-1];
                        ad_reg   <= s_tdata[WORD_W-1] ? (~s_tdata + WORD_W'(1)) : s_tdata;
                        t_reg    <= TWO31 | {{(WORD_W-1){1'b0}}, s_tdata[WORD_W-1]};
                        q2_reg   <= '0;
                        r2_reg   <= '0;
                        idx_reg  <= MSB_IDX;
                        step_reg <= '0;
                        if (s_tdata == '0 || s_tdata == MIN_DIV) begin
                            zero_reg    <= 1'b1;
                            invalid_reg <= 1'b1;
                            state_reg   <= ST_FINISH;
                        end else begin
                            zero_reg    <= 1'b0;
                            invalid_reg <= 1'b0;
                            state_reg   <= ST_DIV_T;
                        end
                    end
                end
                ST_DIV_T: begin
                    q2_reg  <= unit_out.q;
                    r2_reg  <= unit_out.r;
                    idx_reg <= idx_reg - IDX_W'(1);
                    if (idx_reg == '0) begin
                        state_reg <= ST_CALC_ANC;
                    end
                end
                ST_CALC_ANC: begin
                    anc_reg <= anc_next;
                    q1_reg  <= '0;
                    r1_reg  <= '0;
                    idx_reg <= MSB_IDX;
                    if (anc_next == '0) begin
                        zero_reg  <= 1'b1;
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_DIV_ANC;
                    end
                end
                ST_DIV_ANC: begin
                    // index wraps from 0 back to the top bit for the next division
                    q1_reg  <= unit_out.q;
                    r1_reg  <= unit_out.r;
                    idx_reg <= idx_reg - IDX_W'(1);
                    if (idx_reg == '0) begin
                        q2_reg    <= '0;
                        r2_reg    <= '0;
                        state_reg <= ST_DIV_AD;
                    end
                end
                ST_DIV_AD: begin
                    q2_reg  <= unit_out.q;
                    r2_reg  <= unit_out.r;
                    idx_reg <= idx_reg - IDX_W'(1);
                    if (idx_reg == '0) begin
                        state_reg <= ST_STEP2;
                    end
                end
                ST_STEP2: begin
                    q2_reg    <= unit_out.q;
                    r2_reg    <= unit_out.r;
                    step_reg  <= step_reg + STEP_W'(1);
                    state_reg <= ST_STEP1;
                end
                ST_STEP1: begin
                    q1_reg    <= unit_out.q;
                    r1_reg    <= unit_out.r;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (!keep_going || step_reg == MAX_STEPS) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_STEP2;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{(OUT_W-MULT_W-SHIFT_W){1'b0}}, shift_final,
                                         mag_final};
                        m_tuser_reg  <= invalid_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign in_check = (state_reg == ST_CHECK);
    assign rem_ok   = (r2_reg < ad_reg) && (r1_reg < anc_reg);

    // Remainders stay below their divisors during refinement
    `SDMN_ASSERT_NOW(a_rem_bound, aclk, aresetn, in_check, rem_ok)
    // Step counter never passes its bound
    `SDMN_ASSERT_NOW(a_step_bound, aclk, aresetn, 1'b1, step_reg <= MAX_STEPS)
    // An invalid result carries zero multiplier and shift
    `SDMN_ASSERT_NOW(a_invalid_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    // An accepted divisor starts work and blocks further input
    `SDMN_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire

// ----- tb/sv/signed_division_magic_number_unit_test.sv -----
// Self-checking stream testbench for the signed division magic number unit.
`timescale 1ns / 1ps

module signed_division_magic_number_unit_test;

    import sdmn_pkg::*;

    localparam int  CYCLE_LIMIT   = 2_000_000;
    localparam int  PHASE_ITEMS   = 450;
    localparam int  TAIL_CYCLES   = 250;     // a bit over the longest divisor latency

    // One expected result transfer
    typedef struct {
        logic [MULT_W-1:0]  mult;
        logic [SHIFT_W-1:0] shift;
        logic               invalid;
    } magic_t;

    // One row of the directed table; fixed == 1 means the result is typed in
    typedef struct {
        logic [WORD_W-1:0] divisor;
        bit                fixed;
        magic_t            want;
    } divisor_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata  = '0;    // [31:0] divisor
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // [33:0] magic_multiplier, [38:34] post_shift
    logic                 m_tuser;          // [0] invalid

    magic_t       pending_magic[$];
    divisor_row_t directed_rows[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           send_idle_pct  = 0;
    int           rcv_idle_pct   = 0;

    signed_division_magic_number_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Magic multiplier and post shift for one divisor, absolute-value method
    function automatic magic_t predict_magic(input logic [WORD_W-1:0] d);
        magic_t      res;
        logic        neg;
        logic [63:0] ad, t, anc, q1, r1, q2, r2, delta, p, m;
        res = '{default: '0};
        if (d == 32'd0 || d == MIN_DIV) begin
            res.invalid = 1'b1;
            return res;
        end
        neg   = d[WORD_W-1];
        ad    = neg ? {32'd0, 32'd0 - d} : {32'd0, d};
        t     = 64'h8000_0000 + {63'd0, neg};
        anc   = t - 64'd1 - (t % ad);
        p     = 64'd31;
        q1    = 64'h8000_0000 / anc;
        r1    = 64'h8000_0000 - q1 * anc;
        q2    = 64'h8000_0000 / ad;
        r2    = 64'h8000_0000 - q2 * ad;
        for (int k = 0; k < 32; k++) begin
            p  = p + 64'd1;
            q1 = q1 << 1;
            r1 = r1 << 1;
            if (r1 >= anc) begin
                q1 = q1 + 64'd1;
                r1 = r1 - anc;
            end
            q2 = q2 << 1;
            r2 = r2 << 1;
            if (r2 >= ad) begin
                q2 = q2 + 64'd1;
                r2 = r2 - ad;
            end
            delta = ad - r2;
            if (!(q1 < delta || (q1 == delta && r1 == 64'd0)))
                break;
        end
        m = q2 + 64'd1;
        if (neg)
            m = 64'd0 - m;
        res.mult  = m[MULT_W-1:0];
        res.shift = p[SHIFT_W-1:0];    // p - 32, low bits
        return res;
    endfunction

    function automatic divisor_row_t mk_row(input logic [WORD_W-1:0] d, input bit fixed,
                                            input logic [MULT_W-1:0] mult,
                                            input logic [SHIFT_W-1:0] shift,
                                            input logic invalid);
        divisor_row_t row;
        row.divisor      = d;
        row.fixed        = fixed;
        row.want.mult    = mult;
        row.want.shift   = shift;
        row.want.invalid = invalid;
        return row;
    endfunction

    // Offer one divisor, with random idle cycles ahead of it
    task automatic send_divisor(input logic [WORD_W-1:0] d, input bit fixed,
                                input magic_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_magic.push_back(fixed ? want : predict_magic(d));
    endtask

    // Hold the input side until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_magic.size() != 0)
            @(posedge aclk);
    endtask

    // Random divisor, weighted toward small, power-of-two and edge values
    function automatic logic [WORD_W-1:0] pick_divisor();
        logic [WORD_W-1:0] d;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 40)
            d = $urandom;
        else if (pick < 65)
            d = $urandom_range(1000, 1);
        else if (pick < 80)
            d = 32'd1 << $urandom_range(31);
        else if (pick < 90)
            d = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(63)
                                  : 32'h8000_0000 + $urandom_range(63);
        else if (pick < 95)
            d = $urandom_range(1) ? 32'd0 : MIN_DIV;
        else
            d = $urandom_range(32'h0010_0000, 1);
        if (pick >= 40 && pick < 80 && $urandom_range(1))
            d = 32'd0 - d;
        return d;
    endfunction

    // Result side: random backpressure and field checks
    always @(posedge aclk) begin : result_monitor
        magic_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_magic.size() == 0) begin
                    $error("result transfer with no divisor outstanding: tdata=%h tuser=%b",
                           m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = pending_magic.pop_front();
                    if (m_tdata[MULT_W-1:0] !== want.mult) begin
                        $error("magic_multiplier: expected %h, got %h",
                               want.mult, m_tdata[MULT_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[MULT_W+SHIFT_W-1:MULT_W] !== want.shift) begin
                        $error("post_shift: expected %0d, got %0d",
                               want.shift, m_tdata[MULT_W+SHIFT_W-1:MULT_W]);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.invalid) begin
                        $error("invalid: expected %b, got %b", want.invalid, m_tuser);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Stimulus
    initial begin : stimulus
        magic_t no_magic;
        no_magic = '{default: '0};

        // zero and most negative are rejected; +/-1 and 2 are read off directly
        directed_rows = {
            mk_row(32'h0000_0000, 1'b1, 34'h0_0000_0000, 5'd0, 1'b1),
            mk_row(32'h8000_0000, 1'b1, 34'h0_0000_0000, 5'd0, 1'b1),
            mk_row(32'h0000_0001, 1'b1, 34'h1_0000_0001, 5'd0, 1'b0),
            mk_row(32'hFFFF_FFFF, 1'b1, 34'h2_FFFF_FFFF, 5'd0, 1'b0),
            mk_row(32'h0000_0002, 1'b1, 34'h0_8000_0001, 5'd0, 1'b0),
            mk_row(32'hFFFF_FFFE, 1'b0, '0, '0, 1'b0),
            mk_row(32'h0000_0003, 1'b0, '0, '0, 1'b0),
            mk_row(32'hFFFF_FFFD, 1'b0, '0, '0, 1'b0),
            mk_row(32'h0000_0005, 1'b0, '0, '0, 1'b0),
            mk_row(32'hFFFF_FFFB, 1'b0, '0, '0, 1'b0),
            mk_row(32'h0000_0006, 1'b0, '0, '0, 1'b0),
            mk_row(32'h0000_0007, 1'b0, '0, '0, 1'b0),
            mk_row(32'h0000_0019, 1'b0, '0, '0, 1'b0),
            mk_row(32'h0000_007D, 1'b0, '0, '0, 1'b0),
            mk_row(32'h0000_0281, 1'b0, '0, '0, 1'b0),
            mk_row(32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0),
            mk_row(32'h8000_0001, 1'b0, '0, '0, 1'b0),
            mk_row(32'h4000_0000, 1'b0, '0, '0, 1'b0),
            mk_row(32'hC000_0000, 1'b0, '0, '0, 1'b0),
            mk_row(32'h5555_5555, 1'b0, '0, '0, 1'b0),
            mk_row(32'hAAAA_AAAA, 1'b0, '0, '0, 1'b0),
            mk_row(32'h7FFF_FFFE, 1'b0, '0, '0, 1'b0)
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        send_idle_pct = 33;
        rcv_idle_pct  = 74;
        foreach (directed_rows[i])
            send_divisor(directed_rows[i].divisor, directed_rows[i].fixed,
                         directed_rows[i].want);
        drain_results();

        // random phases: receiver idles more, then sender, then neither
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 74 : 0;
            rcv_idle_pct  = (phase == 0) ? 74 : (phase == 1) ? 33 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_divisor(pick_divisor(), 1'b0, no_magic);
            drain_results();
        end

        // let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_magic.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
